FILE: hw/rtl/imhq_pkg.sv
// Package for the indexed min-heap queue: sizes, status codes, command/status structs.
// Used by imhq_ctrl, imhq_dp and indexed_min_heap_queue; depends on nothing.
package imhq_pkg;
	localparam int unsigned CAPACITY_DEF = 256;
	localparam int unsigned ID_COUNT_DEF = 256;
	localparam int unsigned ID_W = 8;
	localparam int unsigned KEY_W = 32;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned COUNT_W = 9;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd4;

	// Datapath commands issued by the controller.
	localparam logic [3:0] CMD_NONE = 4'd0;
	localparam logic [3:0] CMD_LATCH = 4'd1;
	localparam logic [3:0] CMD_RD_ROOT = 4'd2;
	localparam logic [3:0] CMD_POP = 4'd3;
	localparam logic [3:0] CMD_INSERT = 4'd4;
	localparam logic [3:0] CMD_UPDATE = 4'd5;
	localparam logic [3:0] CMD_RD_PAIR = 4'd6;
	localparam logic [3:0] CMD_SWAP = 4'd7;
	localparam logic [3:0] CMD_RD_KIDS = 4'd8;
	localparam logic [3:0] CMD_RD_LOOK = 4'd9;
	localparam logic [3:0] CMD_RD_LAST = 4'd10;
	localparam logic [3:0] CMD_SWAP_DN = 4'd11;
	localparam logic [3:0] CMD_RD_RKID = 4'd12;

	typedef struct packed {
		logic [3:0] op;
	} imhq_cmd_t;

	typedef struct packed {
		logic is_remove;
		logic id_bad;
		logic present;
		logic empty;
		logic full;
		logic up_swap;
		logic at_root;
		logic has_left;
		logic has_right;
		logic left_better;
		logic right_better;
		logic count_zero;
	} imhq_stat_t;
endpackage

FILE: hw/rtl/indexed_min_heap_queue.sv
// Top level of the indexed min-heap queue: joins the controller and the datapath.
// Depends on imhq_pkg, imhq_ctrl and imhq_dp.
//
// This block keeps a binary min-heap of (id, priority) entries with a per-id slot table.
// A set beat (operation 0) inserts a new id or changes the priority of a queued id; a
// remove beat (operation 1) pops the smallest priority, ties resolved by heap order.
// A set with an out-of-range id, or a new id while the heap is full, reports full. Exactly
// one result beat follows each input beat, and a new input beat is taken only after the
// previous result beat has left. Present bits in flip-flops are cleared by reset, so no
// clearing pass is needed after reset.
module indexed_min_heap_queue #(
	parameter int unsigned CAPACITY = imhq_pkg::CAPACITY_DEF,
	parameter int unsigned ID_COUNT = imhq_pkg::ID_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [imhq_pkg::ID_W-1:0]     item_id,
	input  logic [imhq_pkg::KEY_W-1:0]    priority_req,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [imhq_pkg::ID_W-1:0]     out_id,
	output logic [imhq_pkg::KEY_W-1:0]    out_priority,
	output logic [imhq_pkg::STATUS_W-1:0] status,
	output logic [imhq_pkg::COUNT_W-1:0]  count
);
	imhq_pkg::imhq_cmd_t cmd;
	imhq_pkg::imhq_stat_t stat;
	logic [imhq_pkg::ID_W-1:0] rem_id;
	logic [imhq_pkg::KEY_W-1:0] rem_key;

	imhq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd),
		.status_q(status)
	);

	imhq_dp #(.CAPACITY(CAPACITY), .ID_COUNT(ID_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .operation(operation),
		.item_id(item_id), .priority_req(priority_req), .stat(stat),
		.rem_id(rem_id), .rem_key(rem_key), .count_out(count)
	);

	// Removed entry fields show only for a successful remove.
	assign out_id = (status == imhq_pkg::ST_REMOVED) ? rem_id : '0;
	assign out_priority = (status == imhq_pkg::ST_REMOVED) ? rem_key : '0;
endmodule

FILE: hw/rtl/imhq_dp.sv
// Datapath of the indexed min-heap queue: heap id/key memories, per-id slot memory,
// present bits, the working position and compare logic. Depends on imhq_pkg.
module imhq_dp #(
	parameter int unsigned CAPACITY = imhq_pkg::CAPACITY_DEF,
	parameter int unsigned ID_COUNT = imhq_pkg::ID_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  imhq_pkg::imhq_cmd_t                cmd,
	input  logic                               operation,
	input  logic [imhq_pkg::ID_W-1:0]          item_id,
	input  logic [imhq_pkg::KEY_W-1:0]         priority_req,
	output imhq_pkg::imhq_stat_t               stat,
	output logic [imhq_pkg::ID_W-1:0]          rem_id,
	output logic [imhq_pkg::KEY_W-1:0]         rem_key,
	output logic [imhq_pkg::COUNT_W-1:0]       count_out
);
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
	localparam int unsigned KW = imhq_pkg::KEY_W;
	localparam int unsigned DW = imhq_pkg::ID_W;

	logic [DW-1:0] ids_mem [CAPACITY];
	logic [KW-1:0] keys_mem [CAPACITY];
	logic [AW-1:0] slot_mem [ID_COUNT];
	logic [ID_COUNT-1:0] present_q;
	logic [CW-1:0] count_q;
	logic op_q;
	logic [DW-1:0] id_q;
	logic [KW-1:0] key_q;
	logic [CW:0] pos_q;
	logic [AW-1:0] slot_rd_q;
	logic [DW-1:0] a_id_q, b_id_q, c_id_q;
	logic [KW-1:0] a_key_q, b_key_q, c_key_q;
	logic [DW-1:0] out_id_q;
	logic [KW-1:0] out_key_q;

	// Address set used by the read commands.
	logic [CW:0] parent_pos, left_pos, right_pos;
	logic [CW:0] cnt_ext;
	logic id_in_range;
	logic [IW-1:0] id_idx;
	logic left_wins;
	logic [KW-1:0] best_key;

	assign cnt_ext = {1'b0, count_q};
	assign parent_pos = (pos_q - 1'b1) >> 1;
	assign left_pos = {pos_q[CW-1:0], 1'b1};
	assign right_pos = left_pos + 1'b1;
	assign id_in_range = ({24'd0, id_q} < 32'(ID_COUNT));
	assign id_idx = IW'(id_q);
	// a = current entry, b = left child, c = right child during sift-down.
	assign left_wins = b_key_q < a_key_q;
	assign best_key = left_wins ? b_key_q : a_key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			count_q <= '0;
		end else begin
			case (cmd.op)
				imhq_pkg::CMD_POP: begin
					present_q[IW'(a_id_q)] <= 1'b0;
					count_q <= count_q - 1'b1;
				end
				imhq_pkg::CMD_INSERT: begin
					present_q[id_idx] <= 1'b1;
					count_q <= count_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		slot_rd_q <= slot_mem[id_idx];
		case (cmd.op)
			imhq_pkg::CMD_LATCH: begin
				op_q <= operation;
				id_q <= item_id;
				key_q <= priority_req;
			end
			imhq_pkg::CMD_RD_ROOT: begin
				a_id_q <= ids_mem[0];
				a_key_q <= keys_mem[0];
				pos_q <= '0;
			end
			imhq_pkg::CMD_RD_LAST: begin
				b_id_q <= ids_mem[AW'(count_q - 1'b1)];
				b_key_q <= keys_mem[AW'(count_q - 1'b1)];
			end
			imhq_pkg::CMD_POP: begin
				out_id_q <= a_id_q;
				out_key_q <= a_key_q;
				ids_mem[0] <= b_id_q;
				keys_mem[0] <= b_key_q;
				slot_mem[IW'(b_id_q)] <= '0;
				a_id_q <= b_id_q;
				a_key_q <= b_key_q;
			end
			imhq_pkg::CMD_INSERT: begin
				ids_mem[AW'(count_q)] <= id_q;
				keys_mem[AW'(count_q)] <= key_q;
				slot_mem[id_idx] <= AW'(count_q);
				pos_q <= (CW+1)'(count_q);
				a_id_q <= id_q;
				a_key_q <= key_q;
				out_id_q <= '0;
				out_key_q <= '0;
			end
			imhq_pkg::CMD_UPDATE: begin
				keys_mem[slot_rd_q] <= key_q;
				pos_q <= (CW+1)'(slot_rd_q);
				a_id_q <= id_q;
				a_key_q <= key_q;
				out_id_q <= '0;
				out_key_q <= '0;
			end
			imhq_pkg::CMD_RD_PAIR: begin
				b_id_q <= ids_mem[AW'(parent_pos)];
				b_key_q <= keys_mem[AW'(parent_pos)];
			end
			imhq_pkg::CMD_SWAP: begin
				ids_mem[AW'(parent_pos)] <= a_id_q;
				keys_mem[AW'(parent_pos)] <= a_key_q;
				ids_mem[AW'(pos_q)] <= b_id_q;
				keys_mem[AW'(pos_q)] <= b_key_q;
				slot_mem[IW'(a_id_q)] <= AW'(parent_pos);
				slot_mem[IW'(b_id_q)] <= AW'(pos_q);
				pos_q <= parent_pos;
			end
			imhq_pkg::CMD_RD_KIDS: begin
				b_id_q <= ids_mem[AW'(left_pos)];
				b_key_q <= keys_mem[AW'(left_pos)];
			end
			imhq_pkg::CMD_RD_RKID: begin
				c_id_q <= ids_mem[AW'(right_pos)];
				c_key_q <= keys_mem[AW'(right_pos)];
			end
			imhq_pkg::CMD_SWAP_DN: begin
				// Move the chosen child up into pos; current entry drops to the child slot.
				if (stat.right_better) begin
					ids_mem[AW'(pos_q)] <= c_id_q;
					keys_mem[AW'(pos_q)] <= c_key_q;
					ids_mem[AW'(right_pos)] <= a_id_q;
					keys_mem[AW'(right_pos)] <= a_key_q;
					slot_mem[IW'(c_id_q)] <= AW'(pos_q);
					slot_mem[IW'(a_id_q)] <= AW'(right_pos);
					pos_q <= right_pos;
				end else begin
					ids_mem[AW'(pos_q)] <= b_id_q;
					keys_mem[AW'(pos_q)] <= b_key_q;
					ids_mem[AW'(left_pos)] <= a_id_q;
					keys_mem[AW'(left_pos)] <= a_key_q;
					slot_mem[IW'(b_id_q)] <= AW'(pos_q);
					slot_mem[IW'(a_id_q)] <= AW'(left_pos);
					pos_q <= left_pos;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.is_remove = op_q;
		stat.id_bad = !id_in_range;
		stat.present = present_q[id_idx];
		stat.empty = (count_q == '0);
		stat.full = (cnt_ext >= (CW+1)'(CAPACITY));
		stat.up_swap = b_key_q > a_key_q;
		stat.at_root = (pos_q == '0);
		stat.has_left = left_pos < cnt_ext;
		stat.has_right = right_pos < cnt_ext;
		stat.left_better = left_wins;
		stat.right_better = stat.has_right && (c_key_q < best_key);
		stat.count_zero = (count_q == '0);
	end

	assign rem_id = out_id_q;
	assign rem_key = out_key_q;
	assign count_out = imhq_pkg::COUNT_W'(count_q);
endmodule

FILE: hw/rtl/imhq_ctrl.sv
// Controller of the indexed min-heap queue: sequences reads, swaps and sift loops,
// and owns the input/output handshake. Depends on imhq_pkg.
module imhq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  imhq_pkg::imhq_stat_t          stat,
	output imhq_pkg::imhq_cmd_t           cmd,
	output logic [imhq_pkg::STATUS_W-1:0] status_q
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC = 4'd1;
	localparam logic [3:0] S_LAST = 4'd2;
	localparam logic [3:0] S_POP = 4'd3;
	localparam logic [3:0] S_UPRD = 4'd4;
	localparam logic [3:0] S_UPCMP = 4'd5;
	localparam logic [3:0] S_DNRD = 4'd6;
	localparam logic [3:0] S_DNRR = 4'd7;
	localparam logic [3:0] S_DNCMP = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;
	localparam logic [3:0] S_SLOT = 4'd10;

	logic [3:0] state_q, state_d;
	logic [imhq_pkg::STATUS_W-1:0] status_d;
	logic up_then_down_q, up_then_down_d;

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_comb begin
		state_d = state_q;
		status_d = status_q;
		up_then_down_d = up_then_down_q;
		cmd.op = imhq_pkg::CMD_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.op = imhq_pkg::CMD_LATCH;
					state_d = S_SLOT;
				end
			end
			S_SLOT: begin
				// Slot memory read of the latched id is registered here, ready for S_DEC.
				state_d = S_DEC;
			end
			S_DEC: begin
				if (stat.is_remove) begin
					if (stat.empty) begin
						status_d = imhq_pkg::ST_EMPTY;
						state_d = S_DONE;
					end else begin
						cmd.op = imhq_pkg::CMD_RD_ROOT;
						status_d = imhq_pkg::ST_REMOVED;
						state_d = S_LAST;
					end
				end else if (stat.id_bad) begin
					status_d = imhq_pkg::ST_FULL;
					state_d = S_DONE;
				end else if (stat.present) begin
					cmd.op = imhq_pkg::CMD_UPDATE;
					status_d = imhq_pkg::ST_UPDATED;
					up_then_down_d = 1'b1;
					state_d = S_UPRD;
				end else if (stat.full) begin
					status_d = imhq_pkg::ST_FULL;
					state_d = S_DONE;
				end else begin
					cmd.op = imhq_pkg::CMD_INSERT;
					status_d = imhq_pkg::ST_INSERTED;
					up_then_down_d = 1'b0;
					state_d = S_UPRD;
				end
			end
			S_LAST: begin
				cmd.op = imhq_pkg::CMD_RD_LAST;
				state_d = S_POP;
			end
			S_POP: begin
				cmd.op = imhq_pkg::CMD_POP;
				state_d = S_DNRD;
			end
			S_UPRD: begin
				if (stat.at_root) begin
					state_d = up_then_down_q ? S_DNRD : S_DONE;
				end else begin
					cmd.op = imhq_pkg::CMD_RD_PAIR;
					state_d = S_UPCMP;
				end
			end
			S_UPCMP: begin
				if (stat.up_swap) begin
					cmd.op = imhq_pkg::CMD_SWAP;
					state_d = S_UPRD;
				end else begin
					state_d = up_then_down_q ? S_DNRD : S_DONE;
				end
			end
			S_DNRD: begin
				if (stat.count_zero || !stat.has_left) begin
					state_d = S_DONE;
				end else begin
					cmd.op = imhq_pkg::CMD_RD_KIDS;
					state_d = S_DNRR;
				end
			end
			S_DNRR: begin
				cmd.op = imhq_pkg::CMD_RD_RKID;
				state_d = S_DNCMP;
			end
			S_DNCMP: begin
				if (stat.left_better || stat.right_better) begin
					cmd.op = imhq_pkg::CMD_SWAP_DN;
					state_d = S_DNRD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			status_q <= imhq_pkg::ST_INSERTED;
			up_then_down_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			status_q <= status_d;
			up_then_down_q <= up_then_down_d;
			if (state_q == S_DONE) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("input accepted while busy");
	a_done_raises_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> out_valid)
		else $error("result not presented after completion");
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_SLOT))
		else $error("accepted beat did not start work");
`endif
endmodule
